// ===== rtl/stt_pkg.sv =====
`default_nettype none
package stt_pkg;

  localparam int LINE_WIDTH   = 20;
  localparam int COLUMN_WIDTH = 16;

  // at most three tokens come out of one input word
  localparam int MAX_TOKENS  = 3;
  localparam int TOK_CNT_W   = $clog2(MAX_TOKENS + 1);
  localparam int QUEUE_DEPTH = 4;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int FRAC_KEEP   = 9;

  typedef logic [7:0] byte_t;
  typedef logic [5:0] kind_t;

  typedef struct packed {
    byte_t text_byte;
    logic  final_byte;
  } in_word_t;

  typedef struct packed {
    kind_t                   token_kind;
    logic [LINE_WIDTH-1:0]   start_line;
    logic [COLUMN_WIDTH-1:0] start_column;
    logic [7:0]              token_length;
    logic [31:0]             integer_part;
    logic [29:0]             fraction_digits;
    logic [3:0]              fraction_count;
    logic                    run_end;
  } out_word_t;

  // scanner modes
  localparam logic [2:0] MODE_IDLE  = 3'd0;
  localparam logic [2:0] MODE_HELD  = 3'd1;
  localparam logic [2:0] MODE_IDENT = 3'd2;
  localparam logic [2:0] MODE_INT   = 3'd3;
  localparam logic [2:0] MODE_DOT   = 3'd4;
  localparam logic [2:0] MODE_FRAC  = 3'd5;

  // token kinds
  localparam kind_t K_LPAREN = 6'd0;
  localparam kind_t K_RPAREN = 6'd1;
  localparam kind_t K_LBRACK = 6'd2;
  localparam kind_t K_RBRACK = 6'd3;
  localparam kind_t K_LBRACE = 6'd4;
  localparam kind_t K_RBRACE = 6'd5;
  localparam kind_t K_HASH   = 6'd6;
  localparam kind_t K_COMMA  = 6'd7;
  localparam kind_t K_DOT    = 6'd8;
  localparam kind_t K_DEC    = 6'd9;
  localparam kind_t K_MINUS  = 6'd10;
  localparam kind_t K_INC    = 6'd11;
  localparam kind_t K_PLUS   = 6'd12;
  localparam kind_t K_SEMI   = 6'd13;
  localparam kind_t K_SCOPE  = 6'd14;
  localparam kind_t K_COLON  = 6'd15;
  localparam kind_t K_SLASH  = 6'd16;
  localparam kind_t K_STAR   = 6'd17;
  localparam kind_t K_NE     = 6'd18;
  localparam kind_t K_BANG   = 6'd19;
  localparam kind_t K_EQ     = 6'd20;
  localparam kind_t K_ASSIGN = 6'd21;
  localparam kind_t K_GE     = 6'd22;
  localparam kind_t K_SHR    = 6'd23;
  localparam kind_t K_GT     = 6'd24;
  localparam kind_t K_LE     = 6'd25;
  localparam kind_t K_SHL    = 6'd26;
  localparam kind_t K_LT     = 6'd27;
  localparam kind_t K_LAND   = 6'd28;
  localparam kind_t K_AMP    = 6'd29;
  localparam kind_t K_LOR    = 6'd30;
  localparam kind_t K_PIPE   = 6'd31;
  localparam kind_t K_AT     = 6'd32;
  localparam kind_t K_CARET  = 6'd33;
  localparam kind_t K_TILDE  = 6'd34;
  localparam kind_t K_NUMBER = 6'd35;
  localparam kind_t K_IDENT  = 6'd36;
  localparam kind_t K_NONE   = 6'd63;

  // characters
  localparam byte_t CH_TAB   = 8'h09;
  localparam byte_t CH_LF    = 8'h0A;
  localparam byte_t CH_VT    = 8'h0B;
  localparam byte_t CH_FF    = 8'h0C;
  localparam byte_t CH_CR    = 8'h0D;
  localparam byte_t CH_SPACE = 8'h20;
  localparam byte_t CH_DOT   = 8'h2E;
  localparam byte_t CH_ZERO  = 8'h30;
  localparam byte_t CH_NINE  = 8'h39;
  localparam byte_t CH_UNDER = 8'h5F;

  typedef struct packed {
    logic [2:0]              mode;
    byte_t                   held;
    logic [LINE_WIDTH-1:0]   cur_line;
    logic [COLUMN_WIDTH-1:0] cur_col;
    logic [LINE_WIDTH-1:0]   tok_line;
    logic [COLUMN_WIDTH-1:0] tok_col;
    logic [7:0]              count;
    logic [31:0]             int_acc;
    logic [29:0]             frac_acc;
    logic [3:0]              frac_cnt;
    logic [COLUMN_WIDTH-1:0] dot_col;
  } scan_state_t;

  localparam scan_state_t SCAN_RESET = '{
    mode:     MODE_IDLE,
    held:     '0,
    cur_line: LINE_WIDTH'(1),
    cur_col:  COLUMN_WIDTH'(1),
    tok_line: LINE_WIDTH'(1),
    tok_col:  COLUMN_WIDTH'(1),
    count:    '0,
    int_acc:  '0,
    frac_acc: '0,
    frac_cnt: '0,
    dot_col:  COLUMN_WIDTH'(1)
  };

endpackage
`default_nettype wire

// ===== rtl/stt_step.sv =====
`default_nettype none
module stt_step (
  input  stt_pkg::scan_state_t                     st,
  input  stt_pkg::in_word_t                        word,
  output stt_pkg::scan_state_t                     st_next,
  output stt_pkg::out_word_t [stt_pkg::MAX_TOKENS-1:0] toks,
  output logic [stt_pkg::TOK_CNT_W-1:0]            tok_cnt
);
  import stt_pkg::*;

  typedef struct packed {
    logic [1:0] cnt;
    out_word_t  first;
    out_word_t  second;
  } flush_t;

  function automatic logic is_digit(input byte_t c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic is_alpha(input byte_t c);
    return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
  endfunction

  function automatic logic is_word(input byte_t c);
    return (c == CH_UNDER) || is_alpha(c) || is_digit(c);
  endfunction

  function automatic logic is_space(input byte_t c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_VT) ||
           (c == CH_FF) || (c == CH_CR);
  endfunction

  function automatic kind_t solo_kind(input byte_t c);
    kind_t k;
    unique case (c)
      "(":     k = K_LPAREN;
      ")":     k = K_RPAREN;
      "[":     k = K_LBRACK;
      "]":     k = K_RBRACK;
      "{":     k = K_LBRACE;
      "}":     k = K_RBRACE;
      "#":     k = K_HASH;
      ",":     k = K_COMMA;
      ".":     k = K_DOT;
      ";":     k = K_SEMI;
      "/":     k = K_SLASH;
      "*":     k = K_STAR;
      "@":     k = K_AT;
      "^":     k = K_CARET;
      "~":     k = K_TILDE;
      default: k = K_NONE;
    endcase
    return k;
  endfunction

  function automatic kind_t first_kind(input byte_t c);
    kind_t k;
    unique case (c)
      "-":     k = K_MINUS;
      "+":     k = K_PLUS;
      ":":     k = K_COLON;
      "!":     k = K_BANG;
      "=":     k = K_ASSIGN;
      ">":     k = K_GT;
      "<":     k = K_LT;
      "&":     k = K_AMP;
      "|":     k = K_PIPE;
      default: k = K_NONE;
    endcase
    return k;
  endfunction

  function automatic kind_t pair_kind(input byte_t a, input byte_t b);
    kind_t k;
    unique case ({a, b})
      "--":    k = K_DEC;
      "++":    k = K_INC;
      "::":    k = K_SCOPE;
      "!=":    k = K_NE;
      "==":    k = K_EQ;
      ">=":    k = K_GE;
      ">>":    k = K_SHR;
      "<=":    k = K_LE;
      "<<":    k = K_SHL;
      "&&":    k = K_LAND;
      "||":    k = K_LOR;
      default: k = K_NONE;
    endcase
    return k;
  endfunction

  function automatic out_word_t make_tok(
    input kind_t                   kind,
    input logic [LINE_WIDTH-1:0]   line,
    input logic [COLUMN_WIDTH-1:0] col,
    input logic [7:0]              len,
    input logic [31:0]             ip,
    input logic [29:0]             fd,
    input logic [3:0]              fc
  );
    out_word_t t;
    t.token_kind      = kind;
    t.start_line      = line;
    t.start_column    = col;
    t.token_length    = len;
    t.integer_part    = ip;
    t.fraction_digits = fd;
    t.fraction_count  = fc;
    t.run_end         = 1'b0;
    return t;
  endfunction

  // emit whatever tokens the state holds
  function automatic flush_t flush_tokens(input scan_state_t s);
    flush_t f;
    f = '0;
    unique case (s.mode)
      MODE_HELD: begin
        f.cnt   = 2'd1;
        f.first = make_tok(first_kind(s.held), s.tok_line, s.tok_col, 8'd1, '0, '0, '0);
      end
      MODE_IDENT: begin
        f.cnt   = 2'd1;
        f.first = make_tok(K_IDENT, s.tok_line, s.tok_col, s.count, '0, '0, '0);
      end
      MODE_INT, MODE_FRAC: begin
        f.cnt   = 2'd1;
        f.first = make_tok(K_NUMBER, s.tok_line, s.tok_col, s.count, s.int_acc,
                           s.frac_acc, s.frac_cnt);
      end
      MODE_DOT: begin
        // number then a dot that no digit followed
        f.cnt    = 2'd2;
        f.first  = make_tok(K_NUMBER, s.tok_line, s.tok_col, s.count, s.int_acc,
                            s.frac_acc, s.frac_cnt);
        f.second = make_tok(K_DOT, s.tok_line, s.dot_col, 8'd1, '0, '0, '0);
      end
      default: f.cnt = 2'd0;
    endcase
    return f;
  endfunction

  byte_t       c;
  logic [3:0]  digit;
  logic [35:0] int_wide;
  logic [29:0] frac_wide;
  logic [7:0]  len_inc1;
  logic [7:0]  len_inc2;
  kind_t       pair_k;
  kind_t       solo_k;

  assign c      = word.text_byte;
  // low nibble of an ASCII digit is its value
  assign digit  = c[3:0];
  assign pair_k = pair_kind(st.held, c);
  assign solo_k = solo_kind(c);

  assign int_wide  = ({4'b0, st.int_acc} << 3) + ({4'b0, st.int_acc} << 1) + 36'(digit);
  assign frac_wide = (st.frac_acc << 3) + (st.frac_acc << 1) + 30'(digit);
  assign len_inc1  = (st.count == 8'hFF) ? 8'hFF : st.count + 8'd1;
  assign len_inc2  = (st.count >= 8'hFE) ? 8'hFF : st.count + 8'd2;

  scan_state_t nx;
  out_word_t [MAX_TOKENS-1:0] tk;
  logic [TOK_CNT_W-1:0] n;
  logic used;
  flush_t fl;
  flush_t fl_fin;

  always_comb begin
    nx     = st;
    tk     = '0;
    n      = '0;
    used   = 1'b0;
    fl     = '0;
    fl_fin = '0;

    unique case (st.mode)
      MODE_HELD: begin
        if (pair_k != K_NONE) begin
          tk[n]   = make_tok(pair_k, st.tok_line, st.tok_col, 8'd2, '0, '0, '0);
          n       = n + TOK_CNT_W'(1);
          nx.mode = MODE_IDLE;
          nx.held = '0;
          used    = 1'b1;
        end
      end
      MODE_IDENT: begin
        if (is_word(c)) begin
          nx.count = len_inc1;
          used     = 1'b1;
        end
      end
      MODE_INT: begin
        if (is_digit(c)) begin
          nx.int_acc = (int_wide[35:32] != 4'd0) ? 32'hFFFF_FFFF : int_wide[31:0];
          nx.count   = len_inc1;
          used       = 1'b1;
        end else if (c == CH_DOT) begin
          nx.mode    = MODE_DOT;
          nx.dot_col = st.cur_col;
          used       = 1'b1;
        end
      end
      MODE_DOT, MODE_FRAC: begin
        if (is_digit(c)) begin
          nx.count = (st.mode == MODE_DOT) ? len_inc2 : len_inc1;
          nx.mode  = MODE_FRAC;
          // drop digits past the ninth
          if (st.frac_cnt < 4'(FRAC_KEEP)) begin
            nx.frac_acc = frac_wide;
            nx.frac_cnt = st.frac_cnt + 4'd1;
          end
          used = 1'b1;
        end
      end
      default: used = 1'b0;
    endcase

    if (!used) begin
      fl = flush_tokens(st);
      if (fl.cnt != 2'd0) begin
        tk[n] = fl.first;
        n     = n + TOK_CNT_W'(1);
      end
      if (fl.cnt == 2'd2) begin
        tk[n] = fl.second;
        n     = n + TOK_CNT_W'(1);
      end
      nx.mode = MODE_IDLE;
      nx.held = '0;

      if (!is_space(c)) begin
        if (solo_k != K_NONE) begin
          tk[n] = make_tok(solo_k, st.cur_line, st.cur_col, 8'd1, '0, '0, '0);
          n     = n + TOK_CNT_W'(1);
        end else if ((first_kind(c) != K_NONE) || is_digit(c) || (c == CH_UNDER) ||
                     is_alpha(c)) begin
          nx.tok_line = st.cur_line;
          nx.tok_col  = st.cur_col;
          nx.count    = 8'd1;
          nx.int_acc  = '0;
          nx.frac_acc = '0;
          nx.frac_cnt = '0;
          if (first_kind(c) != K_NONE) begin
            nx.mode = MODE_HELD;
            nx.held = c;
          end else if (is_digit(c)) begin
            nx.mode    = MODE_INT;
            nx.int_acc = 32'(digit);
          end else begin
            nx.mode = MODE_IDENT;
          end
        end
      end
    end

    // position of the next byte, saturating
    if (c == CH_LF) begin
      if (st.cur_line != '1) nx.cur_line = st.cur_line + LINE_WIDTH'(1);
      nx.cur_col = COLUMN_WIDTH'(1);
    end else if (st.cur_col != '1) begin
      nx.cur_col = st.cur_col + COLUMN_WIDTH'(1);
    end

    if (word.final_byte) begin
      fl_fin = flush_tokens(nx);
      if (fl_fin.cnt != 2'd0) begin
        tk[n] = fl_fin.first;
        n     = n + TOK_CNT_W'(1);
      end
      if (fl_fin.cnt == 2'd2) begin
        tk[n] = fl_fin.second;
        n     = n + TOK_CNT_W'(1);
      end
      nx = SCAN_RESET;
    end

    if (n != '0) tk[n - TOK_CNT_W'(1)].run_end = 1'b1;
  end

  assign st_next = nx;
  assign toks    = tk;
  assign tok_cnt = n;

endmodule
`default_nettype wire

// ===== rtl/stt_queue.sv =====
`default_nettype none
module stt_queue (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic [stt_pkg::TOK_CNT_W-1:0]            wr_cnt,
  input  stt_pkg::out_word_t [stt_pkg::MAX_TOKENS-1:0] wr_data,
  output logic                                     room,
  output logic                                     rd_valid,
  input  logic                                     rd_ready,
  output stt_pkg::out_word_t                       rd_data
);
  import stt_pkg::*;

  out_word_t mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   count;
  logic             pop;

  assign rd_valid = (count != '0);
  assign pop      = rd_valid && rd_ready;
  // room for the largest burst one input word can cause
  assign room     = (count <= (PTR_W + 1)'(QUEUE_DEPTH - MAX_TOKENS));
  assign rd_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PTR_W'(wr_cnt);
      rd_ptr <= rd_ptr + PTR_W'(pop);
      count  <= count + (PTR_W + 1)'(wr_cnt) - (PTR_W + 1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_TOKENS; i++) begin
      if (TOK_CNT_W'(i) < wr_cnt) mem[wr_ptr + PTR_W'(i)] <= wr_data[i];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/source_text_tokenizer.sv =====
// Streaming tokenizer for source text.
// Input channel (in_valid/in_ready/in_word): one text byte per word, with
// final_byte set on the last byte of a text. Output channel
// (out_valid/out_ready/out_word): one token per word with its kind, start
// line and column, length and, for numbers, integer and fraction parts;
// run_end marks the last token caused by one input byte.
// Each byte is decoded combinationally against the scanner state and yields
// zero to three tokens, which land in a four-entry token queue; each token
// is offered on out_word once the tokens ahead of it have been taken.
// Throughput: one byte per cycle while the queue has room; sustained, the
// rate is set by the single-token output port. in_ready is high whenever
// the queue has room for three tokens, so the input keeps flowing while a
// finished token waits on a stalled receiver. Reset empties the queue and
// returns the scanner to line 1, column 1; a final byte returns the scanner
// there after its tokens are queued.
`default_nettype none
module source_text_tokenizer (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  stt_pkg::in_word_t  in_word,
  output logic               out_valid,
  input  logic               out_ready,
  output stt_pkg::out_word_t out_word
);
  import stt_pkg::*;

  scan_state_t st;
  scan_state_t st_next;
  out_word_t [MAX_TOKENS-1:0] toks;
  logic [TOK_CNT_W-1:0] tok_cnt;
  logic [TOK_CNT_W-1:0] wr_cnt;
  logic room;
  logic accept;

  assign in_ready = room;
  assign accept   = in_valid && in_ready;
  assign wr_cnt   = accept ? tok_cnt : '0;

  stt_step u_step (
    .st      (st),
    .word    (in_word),
    .st_next (st_next),
    .toks    (toks),
    .tok_cnt (tok_cnt)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= SCAN_RESET;
    end else if (accept) begin
      st <= st_next;
    end
  end

  stt_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_cnt   (wr_cnt),
    .wr_data  (toks),
    .room     (room),
    .rd_valid (out_valid),
    .rd_ready (out_ready),
    .rd_data  (out_word)
  );

endmodule
`default_nettype wire

// ===== rtl/stt_checker.sv =====
`default_nettype none
module stt_checker (
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_ready,
  input stt_pkg::out_word_t out_word
);
  import stt_pkg::*;

  // a stalled word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_word))
    else $error("output word changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

  a_non_number: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_word.token_kind != K_NUMBER) |->
      (out_word.integer_part == '0) && (out_word.fraction_digits == '0) &&
      (out_word.fraction_count == '0))
    else $error("numeric fields set on a token that is not a number");

  a_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_word.token_kind <= K_IDENT) &&
      (out_word.fraction_count <= 4'(FRAC_KEEP)) &&
      (out_word.token_length != '0) && (out_word.start_line != '0) &&
      (out_word.start_column != '0))
    else $error("token fields out of range");

  a_short_ops: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_word.token_kind < K_NUMBER) |-> (out_word.token_length <= 8'd2))
    else $error("operator token longer than two characters");

endmodule

bind source_text_tokenizer stt_checker u_stt_checker (.*);
`default_nettype wire

// ===== tb/sv/tb_source_text_tokenizer.sv =====
`default_nettype none
module tb_source_text_tokenizer;
  import stt_pkg::*;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_word_t  in_word = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_word_t out_word;

  source_text_tokenizer uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
  );

  always #10 clk = ~clk;

  initial begin
    #40_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // scanner copy used for prediction
  logic [2:0]              p_mode;
  byte_t                   p_held;
  logic [LINE_WIDTH-1:0]   p_line;
  logic [COLUMN_WIDTH-1:0] p_col;
  logic [LINE_WIDTH-1:0]   t_line;
  logic [COLUMN_WIDTH-1:0] t_col;
  logic [7:0]              t_len;
  logic [31:0]             acc_int;
  logic [29:0]             acc_frac;
  logic [3:0]              frac_n;
  logic [COLUMN_WIDTH-1:0] dot_at;

  out_word_t step_tok[$];
  out_word_t expected_tokens[$];
  in_word_t  pending_text[$];
  int        mismatches = 0;
  int        text_items = 0;
  int        tx_idle_pct = 0;
  int        rx_idle_pct = 0;
  int        stall_req = 0;
  int        stall_seen = 0;
  int        hold_left = 0;

  string op_chars   = "()[]{}#,.;/*@^~-+:!=><&|";
  string pair_chars = "-+:=><&|";
  string word_chars =
    "_ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789";
  byte_t blank_set[6] = '{CH_SPACE, CH_TAB, CH_LF, CH_CR, CH_VT, CH_FF};

  typedef struct {
    in_word_t  w;
    bit        typed;
    bit        has_tok;
    out_word_t want;
  } probe_t;
  probe_t probes[$];

  function automatic bit is_digit(byte_t c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  function automatic bit is_alpha(byte_t c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic bit is_word(byte_t c);
    return c == CH_UNDER || is_alpha(c) || is_digit(c);
  endfunction

  function automatic bit is_space(byte_t c);
    return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_VT ||
           c == CH_FF || c == CH_CR;
  endfunction

  function automatic kind_t solo_kind(byte_t c);
    case (c)
      "(": return K_LPAREN;
      ")": return K_RPAREN;
      "[": return K_LBRACK;
      "]": return K_RBRACK;
      "{": return K_LBRACE;
      "}": return K_RBRACE;
      "#": return K_HASH;
      ",": return K_COMMA;
      ".": return K_DOT;
      ";": return K_SEMI;
      "/": return K_SLASH;
      "*": return K_STAR;
      "@": return K_AT;
      "^": return K_CARET;
      "~": return K_TILDE;
      default: return K_NONE;
    endcase
  endfunction

  function automatic kind_t first_kind(byte_t c);
    case (c)
      "-": return K_MINUS;
      "+": return K_PLUS;
      ":": return K_COLON;
      "!": return K_BANG;
      "=": return K_ASSIGN;
      ">": return K_GT;
      "<": return K_LT;
      "&": return K_AMP;
      "|": return K_PIPE;
      default: return K_NONE;
    endcase
  endfunction

  function automatic kind_t pair_kind(byte_t a, byte_t b);
    if (a == "-" && b == "-") return K_DEC;
    if (a == "+" && b == "+") return K_INC;
    if (a == ":" && b == ":") return K_SCOPE;
    if (a == "!" && b == "=") return K_NE;
    if (a == "=" && b == "=") return K_EQ;
    if (a == ">" && b == "=") return K_GE;
    if (a == ">" && b == ">") return K_SHR;
    if (a == "<" && b == "=") return K_LE;
    if (a == "<" && b == "<") return K_SHL;
    if (a == "&" && b == "&") return K_LAND;
    if (a == "|" && b == "|") return K_LOR;
    return K_NONE;
  endfunction

  task automatic clear_scan();
    p_mode   = MODE_IDLE;
    p_held   = '0;
    p_line   = LINE_WIDTH'(1);
    p_col    = COLUMN_WIDTH'(1);
    t_line   = LINE_WIDTH'(1);
    t_col    = COLUMN_WIDTH'(1);
    t_len    = '0;
    acc_int  = '0;
    acc_frac = '0;
    frac_n   = '0;
    dot_at   = COLUMN_WIDTH'(1);
  endtask

  task automatic put_tok(kind_t k, logic [LINE_WIDTH-1:0] ln, logic [COLUMN_WIDTH-1:0] cl,
                         logic [7:0] len, logic [31:0] ip, logic [29:0] fd,
                         logic [3:0] fc);
    out_word_t t;
    t = '{token_kind: k, start_line: ln, start_column: cl, token_length: len,
          integer_part: ip, fraction_digits: fd, fraction_count: fc, run_end: 1'b0};
    if (step_tok.size() < MAX_TOKENS) step_tok.push_back(t);
  endtask

  task automatic grow(int k);
    int s;
    s = int'(t_len) + k;
    t_len = (s > 255) ? 8'd255 : 8'(s);
  endtask

  task automatic open_token(logic [2:0] mode, logic [LINE_WIDTH-1:0] ln,
                            logic [COLUMN_WIDTH-1:0] cl);
    p_mode   = mode;
    t_line   = ln;
    t_col    = cl;
    t_len    = 8'd1;
    acc_int  = '0;
    acc_frac = '0;
    frac_n   = '0;
  endtask

  // emit any held token and go idle
  task automatic flush_held();
    case (p_mode)
      MODE_HELD:  put_tok(first_kind(p_held), t_line, t_col, 8'd1, '0, '0, '0);
      MODE_IDENT: put_tok(K_IDENT, t_line, t_col, t_len, '0, '0, '0);
      MODE_INT, MODE_FRAC: put_tok(K_NUMBER, t_line, t_col, t_len, acc_int, acc_frac, frac_n);
      MODE_DOT: begin
        put_tok(K_NUMBER, t_line, t_col, t_len, acc_int, acc_frac, frac_n);
        put_tok(K_DOT, t_line, dot_at, 8'd1, '0, '0, '0);
      end
      default: ;
    endcase
    p_mode = MODE_IDLE;
    p_held = '0;
  endtask

  task automatic tokenize_byte(in_word_t w);
    byte_t                   c;
    logic [LINE_WIDTH-1:0]   ln;
    logic [COLUMN_WIDTH-1:0] cl;
    bit                      used;
    kind_t                   k;
    logic [63:0]             wide;
    c = w.text_byte;
    ln = p_line;
    cl = p_col;
    used = 1'b0;
    step_tok.delete();
    case (p_mode)
      MODE_HELD: begin
        k = pair_kind(p_held, c);
        if (k != K_NONE) begin
          put_tok(k, t_line, t_col, 8'd2, '0, '0, '0);
          p_mode = MODE_IDLE;
          p_held = '0;
          used = 1'b1;
        end
      end
      MODE_IDENT: begin
        if (is_word(c)) begin
          grow(1);
          used = 1'b1;
        end
      end
      MODE_INT: begin
        if (is_digit(c)) begin
          wide = 64'(acc_int) * 64'd10 + 64'(c) - 64'(CH_ZERO);
          acc_int = (wide > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : wide[31:0];
          grow(1);
          used = 1'b1;
        end else if (c == CH_DOT) begin
          p_mode = MODE_DOT;
          dot_at = cl;
          used = 1'b1;
        end
      end
      MODE_DOT, MODE_FRAC: begin
        if (is_digit(c)) begin
          grow((p_mode == MODE_DOT) ? 2 : 1);
          p_mode = MODE_FRAC;
          // digits past the ninth only lengthen the token
          if (frac_n < FRAC_KEEP) begin
            acc_frac = acc_frac * 30'd10 + 30'(c - CH_ZERO);
            frac_n = frac_n + 4'd1;
          end
          used = 1'b1;
        end
      end
      default: ;
    endcase

    if (!used) begin
      flush_held();
      k = solo_kind(c);
      if (is_space(c)) begin
      end else if (k != K_NONE) begin
        put_tok(k, ln, cl, 8'd1, '0, '0, '0);
      end else if (first_kind(c) != K_NONE) begin
        open_token(MODE_HELD, ln, cl);
        p_held = c;
      end else if (is_digit(c)) begin
        open_token(MODE_INT, ln, cl);
        acc_int = 32'(c - CH_ZERO);
      end else if (c == CH_UNDER || is_alpha(c)) begin
        open_token(MODE_IDENT, ln, cl);
      end
    end

    if (c == CH_LF) begin
      if (p_line != '1) p_line = p_line + 1'b1;
      p_col = COLUMN_WIDTH'(1);
    end else if (p_col != '1) begin
      p_col = p_col + 1'b1;
    end

    if (w.final_byte) begin
      flush_held();
      clear_scan();
    end
    if (step_tok.size() > 0) step_tok[step_tok.size() - 1].run_end = 1'b1;
  endtask

  task automatic note_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %0d, want %0d", what, got, want);
    mismatches++;
  endtask

  task automatic compare_token(out_word_t got, out_word_t want);
    if (got.token_kind != want.token_kind)
      note_mismatch("token_kind", got.token_kind, want.token_kind);
    if (got.start_line != want.start_line)
      note_mismatch("start_line", got.start_line, want.start_line);
    if (got.start_column != want.start_column)
      note_mismatch("start_column", got.start_column, want.start_column);
    if (got.token_length != want.token_length)
      note_mismatch("token_length", got.token_length, want.token_length);
    if (got.integer_part != want.integer_part)
      note_mismatch("integer_part", got.integer_part, want.integer_part);
    if (got.fraction_digits != want.fraction_digits)
      note_mismatch("fraction_digits", got.fraction_digits, want.fraction_digits);
    if (got.fraction_count != want.fraction_count)
      note_mismatch("fraction_count", got.fraction_count, want.fraction_count);
    if (got.run_end != want.run_end)
      note_mismatch("run_end", got.run_end, want.run_end);
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_tokens.size() == 0) note_mismatch("token with nothing expected",
                                                     out_word.token_kind, K_NONE);
      else compare_token(out_word, expected_tokens.pop_front());
    end
  end

  // receiver: random backpressure, plus a long hold-off on request
  always @(posedge clk) begin
    if (stall_req != stall_seen) begin
      stall_seen = stall_req;
      hold_left = 200;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  task automatic offer(in_word_t w, bit typed, bit has_tok, out_word_t want);
    if ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < tx_idle_pct);
    end
    in_valid <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (!in_ready);
    tokenize_byte(w);
    if (typed) begin
      if (has_tok) expected_tokens.push_back(want);
    end else begin
      foreach (step_tok[i]) expected_tokens.push_back(step_tok[i]);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_tokens.size() != 0);
  endtask

  task automatic add_probe(byte_t c, bit fin);
    probe_t p;
    p.w = '{text_byte: c, final_byte: fin};
    p.typed = 1'b0;
    p.has_tok = 1'b0;
    p.want = '0;
    probes.push_back(p);
  endtask

  task automatic add_typed(byte_t c, bit has_tok, kind_t k, int ln, int cl, int len);
    probe_t p;
    p.w = '{text_byte: c, final_byte: 1'b0};
    p.typed = 1'b1;
    p.has_tok = has_tok;
    p.want = '{token_kind: k, start_line: LINE_WIDTH'(ln), start_column: COLUMN_WIDTH'(cl),
               token_length: 8'(len), integer_part: '0, fraction_digits: '0,
               fraction_count: '0, run_end: 1'b1};
    probes.push_back(p);
  endtask

  function automatic bit coin_end();
    return $urandom_range(0, 49) == 0;
  endfunction

  function automatic byte_t any_digit();
    return byte_t'(CH_ZERO + $urandom_range(0, 9));
  endfunction

  task automatic put_char(byte_t c, bit fin);
    pending_text.push_back('{text_byte: c, final_byte: fin});
    if (!is_space(c)) text_items++;
  endtask

  // mostly well-formed tokens, some blanks and raw noise bytes
  task automatic gen_text(int target);
    int    first;
    int    r;
    int    n;
    byte_t c;
    first = text_items;
    while (text_items - first < target) begin
      r = $urandom_range(0, 99);
      if (r < 22) begin
        c = op_chars[$urandom_range(0, op_chars.len() - 1)];
        put_char(c, coin_end());
        if (first_kind(c) != K_NONE && $urandom_range(0, 1))
          put_char(pair_chars[$urandom_range(0, pair_chars.len() - 1)], coin_end());
      end else if (r < 42) begin
        n = ($urandom_range(0, 99) == 0) ? $urandom_range(250, 300) : $urandom_range(1, 8);
        put_char(word_chars[$urandom_range(0, 52)], coin_end());
        for (int i = 1; i < n; i++) put_char(word_chars[$urandom_range(0, 62)], coin_end());
      end else if (r < 64) begin
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 14) : $urandom_range(1, 4);
        for (int i = 0; i < n; i++) put_char(any_digit(), coin_end());
        r = $urandom_range(0, 9);
        if (r < 5) begin
          put_char(CH_DOT, coin_end());
          n = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 13) : $urandom_range(1, 4);
          for (int i = 0; i < n; i++) put_char(any_digit(), coin_end());
        end else if (r < 7) begin
          put_char(CH_DOT, coin_end());
        end
      end else if (r < 86) begin
        n = $urandom_range(1, 3);
        for (int i = 0; i < n; i++) put_char(blank_set[$urandom_range(0, 5)], coin_end());
      end else begin
        put_char(byte_t'($urandom_range(0, 255)), coin_end());
      end
    end
  endtask

  task automatic send_pending();
    while (pending_text.size() != 0) offer(pending_text.pop_front(), 1'b0, 1'b0, '0);
  endtask

  initial begin
    clear_scan();

    add_typed("(", 1'b1, K_LPAREN, 1, 1, 1);
    add_typed(8'hFF, 1'b0, K_NONE, 0, 0, 0);
    add_typed(8'h00, 1'b0, K_NONE, 0, 0, 0);
    add_typed("~", 1'b1, K_TILDE, 1, 4, 1);
    add_probe(CH_TAB, 1'b0);
    add_probe("-", 1'b0);
    add_typed("-", 1'b1, K_DEC, 1, 6, 2);
    add_probe("-", 1'b0);
    add_probe("x", 1'b0);
    add_probe(CH_LF, 1'b0);
    // integer, dot, then a byte that cannot be a digit
    add_probe("4", 1'b0);
    add_probe("2", 1'b0);
    add_probe(CH_DOT, 1'b0);
    add_probe(")", 1'b0);
    add_probe("3", 1'b0);
    add_probe(CH_DOT, 1'b0);
    add_probe("1", 1'b0);
    add_probe("4", 1'b0);
    add_probe(CH_SPACE, 1'b0);
    add_probe("|", 1'b0);
    add_probe("|", 1'b0);
    add_probe("&", 1'b0);
    add_probe("=", 1'b0);
    add_probe("=", 1'b0);
    add_probe("7", 1'b0);
    add_probe(CH_DOT, 1'b1);
    // final byte puts the position back to line 1, column 1
    add_typed("#", 1'b1, K_HASH, 1, 1, 1);

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    tx_idle_pct = 9;
    rx_idle_pct = 85;
    foreach (probes[i]) offer(probes[i].w, probes[i].typed, probes[i].has_tok, probes[i].want);
    drain();

    gen_text(105);
    stall_req <= stall_req + 1;
    send_pending();
    drain();

    tx_idle_pct = 85;
    rx_idle_pct = 9;
    gen_text(105);
    send_pending();
    drain();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    gen_text(100);
    send_pending();
    drain();

    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
`default_nettype wire
